// ===== rtl/core/fsts_pkg.sv =====
package fsts_pkg;

    localparam int PAGE_SIZE = 4096;
    localparam int PAGE_BITS = $clog2(PAGE_SIZE);

    localparam int ADDR_W = 64;
    localparam int LEN_W = 32;

    localparam logic [LEN_W-1:0] RETRY_RESET = LEN_W'(64 * 1024);

    localparam int S_TDATA_W = 136;
    localparam int M_TDATA_W = 128;

    localparam int CFG_IDX_W = 4;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP_MODE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_THRESHOLD = CFG_IDX_W'(1);

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_COMPLETE = 1'b1;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        OP_START       = 2'd0,
        OP_START_EMPTY = 2'd1,
        OP_COMPLETE    = 2'd2,
        OP_ABORT       = 2'd3
    } op_t;

    // One classified transfer: len carries start_length for starts, bytes_done otherwise.
    typedef struct packed {
        op_t              op;
        logic [ADDR_W-1:0] addr;
        logic [LEN_W-1:0]  len;
    } entry_t;

    typedef struct packed {
        logic valid;
        logic full;
    } q_status_t;

    typedef struct packed {
        logic             skip_mode;
        logic [LEN_W-1:0] retry_threshold;
    } cfg_t;

    function automatic logic [PAGE_BITS:0] page_left(input logic [ADDR_W-1:0] a);
        logic [PAGE_BITS:0] offs;
        begin
            offs = {1'b0, a[PAGE_BITS-1:0]};
            page_left = (PAGE_BITS + 1)'(PAGE_SIZE) - offs;
        end
    endfunction

    function automatic logic [LEN_W-1:0] min_rem(input logic [ADDR_W-1:0] a,
                                                 input logic [LEN_W-1:0] rem);
        logic [LEN_W-1:0] p;
        begin
            p = {{(LEN_W-PAGE_BITS-1){1'b0}}, page_left(a)};
            min_rem = (p < rem) ? p : rem;
        end
    endfunction

endpackage

// ===== rtl/core/fsts_front.sv =====
module fsts_front (
    input  logic [fsts_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                           s_tuser,
    output fsts_pkg::entry_t               entry
);
    import fsts_pkg::*;

    logic [ADDR_W-1:0] start_address;
    logic [LEN_W-1:0]  start_length;
    logic [LEN_W-1:0]  bytes_done;
    logic              fatal_error;

    assign start_address = s_tdata[ADDR_W-1:0];
    assign start_length  = s_tdata[ADDR_W+LEN_W-1:ADDR_W];
    assign bytes_done    = s_tdata[ADDR_W+2*LEN_W-1:ADDR_W+LEN_W];
    assign fatal_error   = s_tdata[ADDR_W+2*LEN_W];

    always_comb begin
        entry.addr = start_address;
        if (s_tuser == KIND_START) begin
            entry.len = start_length;
            if (start_address == '0 || start_length == '0) begin
                entry.op = OP_START_EMPTY;
            end else begin
                entry.op = OP_START;
            end
        end else begin
            entry.len = bytes_done;
            entry.op  = fatal_error ? OP_ABORT : OP_COMPLETE;
        end
    end

endmodule

// ===== rtl/core/fsts_queue.sv =====
module fsts_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  wr_en,
    input  fsts_pkg::entry_t      wr_entry,
    input  logic                  rd_en,
    output fsts_pkg::entry_t      rd_entry,
    output fsts_pkg::q_status_t   status
);
    import fsts_pkg::*;

    entry_t             mem_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        begin
            if (p == QPTR_W'(QDEPTH - 1)) begin
                ptr_inc = '0;
            end else begin
                ptr_inc = p + QPTR_W'(1);
            end
        end
    endfunction

    assign status.valid = (count_reg != '0);
    assign status.full  = (count_reg == QCNT_W'(QDEPTH));
    assign rd_entry     = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_en ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = rd_en ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en && !rd_en) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (!wr_en && rd_en) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_ptr_reg] <= wr_entry;
        end
    end

endmodule

// ===== rtl/core/fsts_back.sv =====
module fsts_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  fsts_pkg::cfg_t                 cfg,
    input  logic                           q_valid,
    input  fsts_pkg::entry_t               q_entry,
    output logic                           q_pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [fsts_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                           m_tuser
);
    import fsts_pkg::*;

    logic [ADDR_W-1:0] cur_address_reg, cur_address_next;
    logic [LEN_W-1:0]  remaining_reg, remaining_next;
    logic [LEN_W-1:0]  total_done_reg, total_done_next;
    logic              page_mode_reg, page_mode_next;
    logic [LEN_W-1:0]  run_bytes_reg, run_bytes_next;
    logic [LEN_W-1:0]  last_request_reg, last_request_next;
    logic              active_reg, active_next;

    logic              out_valid_reg;
    logic [ADDR_W-1:0] out_address_reg, out_address_next;
    logic [LEN_W-1:0]  out_size_reg, out_size_next;
    logic [LEN_W-1:0]  out_total_reg, out_total_next;
    logic              out_finished_reg, out_finished_next;

    logic [LEN_W-1:0]  done;
    logic [LEN_W-1:0]  skip;
    logic [LEN_W-1:0]  size;
    logic [LEN_W:0]    run_sum;
    logic              fin;

    assign q_pop    = q_valid && (!out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_finished_reg;
    assign m_tdata  = {out_total_reg, out_size_reg, out_address_reg};

    always_comb begin
        cur_address_next  = cur_address_reg;
        remaining_next    = remaining_reg;
        total_done_next   = total_done_reg;
        page_mode_next    = page_mode_reg;
        run_bytes_next    = run_bytes_reg;
        last_request_next = last_request_reg;
        active_next       = active_reg;
        fin               = 1'b0;
        done              = (q_entry.len > last_request_reg) ? last_request_reg : q_entry.len;
        skip              = min_rem(cur_address_reg, remaining_reg);
        run_sum           = {1'b0, run_bytes_reg} + {1'b0, done};
        size              = '0;

        case (q_entry.op)
            OP_START, OP_START_EMPTY: begin
                cur_address_next  = q_entry.addr;
                remaining_next    = q_entry.len;
                total_done_next   = '0;
                page_mode_next    = 1'b0;
                run_bytes_next    = '0;
                last_request_next = '0;
                fin               = (q_entry.op == OP_START_EMPTY);
            end
            OP_ABORT: begin
                fin = 1'b1;
            end
            OP_COMPLETE: begin
                if (!active_reg) begin
                    fin = 1'b1;
                end else if (done != '0) begin
                    total_done_next  = total_done_reg + done;
                    cur_address_next = cur_address_reg + {{(ADDR_W-LEN_W){1'b0}}, done};
                    remaining_next   = remaining_reg - done;
                    if (page_mode_reg) begin
                        run_bytes_next = run_sum[LEN_W] ? '1 : run_sum[LEN_W-1:0];
                        if (run_bytes_next >= cfg.retry_threshold) begin
                            page_mode_next = 1'b0;
                            run_bytes_next = '0;
                        end
                    end
                    fin = (done != last_request_reg) && !cfg.skip_mode;
                end else if (!cfg.skip_mode) begin
                    fin = 1'b1;
                end else if (!page_mode_reg) begin
                    page_mode_next = 1'b1;
                    run_bytes_next = '0;
                end else begin
                    cur_address_next = cur_address_reg + {{(ADDR_W-LEN_W){1'b0}}, skip};
                    remaining_next   = remaining_reg - skip;
                    run_bytes_next   = '0;
                end
                if (remaining_next == '0) begin
                    fin = 1'b1;
                end
            end
            default: begin
                fin = 1'b1;
            end
        endcase

        if (page_mode_next) begin
            size = min_rem(cur_address_next, remaining_next);
        end else begin
            size = remaining_next;
        end

        if (fin) begin
            active_next       = 1'b0;
            out_address_next  = '0;
            out_size_next     = '0;
            out_finished_next = 1'b1;
        end else begin
            active_next       = 1'b1;
            last_request_next = size;
            out_address_next  = cur_address_next;
            out_size_next     = size;
            out_finished_next = 1'b0;
        end
        out_total_next = total_done_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_address_reg  <= '0;
            remaining_reg    <= '0;
            total_done_reg   <= '0;
            page_mode_reg    <= 1'b0;
            run_bytes_reg    <= '0;
            last_request_reg <= '0;
            active_reg       <= 1'b0;
            out_valid_reg    <= 1'b0;
        end else begin
            if (q_pop) begin
                cur_address_reg  <= cur_address_next;
                remaining_reg    <= remaining_next;
                total_done_reg   <= total_done_next;
                page_mode_reg    <= page_mode_next;
                run_bytes_reg    <= run_bytes_next;
                last_request_reg <= last_request_next;
                active_reg       <= active_next;
                out_valid_reg    <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            out_address_reg  <= out_address_next;
            out_size_reg     <= out_size_next;
            out_total_reg    <= out_total_next;
            out_finished_reg <= out_finished_next;
        end
    end

endmodule

// ===== rtl/core/fault_skipping_transfer_sequencer.sv =====
// Steps a ranged memory transfer through a backend that may fault. A start transfer
// opens a range and every completion transfer reports the last request; each input
// transfer produces exactly one result: the next request or a finish with the byte
// total. The block sustains one input transfer per cycle while m_axis_tready is high,
// as the back end updates its state on every pop; a result passes through the
// two-entry queue and then the output register.
// Configuration writes are always ready and should only be issued while idle.
module fault_skipping_transfer_sequencer (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [fsts_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fsts_pkg::CFG_DATA_W-1:0] cfg_data,

    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // start_address[63:0], start_length[95:64], bytes_done[127:96],
    // fatal_error[128], zero padding up to bit 135.
    input  logic [fsts_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // kind.
    input  logic                            s_axis_tuser,

    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // request_address[63:0], request_size[95:64], total_bytes[127:96].
    output logic [fsts_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    // finished.
    output logic                            m_axis_tuser
);
    import fsts_pkg::*;

    cfg_t       cfg_reg;
    entry_t     in_entry;
    entry_t     q_entry;
    q_status_t  q_status;
    logic       q_pop;
    logic       s_fire;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !q_status.full;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.skip_mode       <= 1'b0;
            cfg_reg.retry_threshold <= RETRY_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_SKIP_MODE:       cfg_reg.skip_mode       <= cfg_data[0];
                CFG_RETRY_THRESHOLD: cfg_reg.retry_threshold <= cfg_data[LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    fsts_front u_front (
        .s_tdata (s_axis_tdata),
        .s_tuser (s_axis_tuser),
        .entry   (in_entry)
    );

    fsts_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (s_fire),
        .wr_entry (in_entry),
        .rd_en    (q_pop),
        .rd_entry (q_entry),
        .status   (q_status)
    );

    fsts_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_valid  (q_status.valid),
        .q_entry  (q_entry),
        .q_pop    (q_pop),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .m_tdata  (m_axis_tdata),
        .m_tuser  (m_axis_tuser)
    );

`ifndef SYNTHESIS
    a_finish_clears_request: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[95:0] == '0)
        else $error("finished result carries a nonzero request");

    a_request_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[95:64] != '0)
        else $error("request issued with zero size");

    a_empty_start_finishes: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop && q_entry.op == OP_START_EMPTY |=> m_axis_tvalid && m_axis_tuser)
        else $error("empty start did not finish at once");

    a_pop_only_when_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_status.valid)
        else $error("queue read while empty");
`endif

endmodule

// ===== sim/transfer_sequence_checker.sv =====
`timescale 1ns / 100ps

module transfer_sequence_checker (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [fsts_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fsts_pkg::CFG_DATA_W-1:0] cfg_data,

    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    // start_address[63:0], start_length[95:64], bytes_done[127:96], fatal_error[128].
    input  logic [fsts_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // kind.
    input  logic                            s_axis_tuser,

    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // request_address[63:0], request_size[95:64], total_bytes[127:96].
    input  logic [fsts_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    // finished.
    input  logic                            m_axis_tuser,

    output int                              mismatches,
    output int                              outstanding
);
    import fsts_pkg::*;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic [LEN_W-1:0]  size;
        logic              finished;
        logic [LEN_W-1:0]  total;
    } transfer_reply_t;

    transfer_reply_t awaited_replies[$];

    logic              skip_faults = 1'b0;
    logic [LEN_W-1:0]  retry_bytes = RETRY_RESET;

    logic [ADDR_W-1:0] next_addr = '0;
    logic [LEN_W-1:0]  bytes_left = '0;
    logic [LEN_W-1:0]  bytes_moved = '0;
    logic              paging = 1'b0;
    logic [LEN_W-1:0]  clean_run = '0;
    logic [LEN_W-1:0]  issued_size = '0;
    logic              busy = 1'b0;

    function automatic logic [LEN_W-1:0] page_limited(input logic [ADDR_W-1:0] addr);
        logic [ADDR_W-1:0] room;
        room = 64'(PAGE_SIZE) - (addr % 64'(PAGE_SIZE));
        page_limited = (room < {32'b0, bytes_left}) ? room[LEN_W-1:0] : bytes_left;
    endfunction

    function automatic transfer_reply_t sequence_step(input logic kind,
                                                      input logic [ADDR_W-1:0] start_addr,
                                                      input logic [LEN_W-1:0] start_len,
                                                      input logic [LEN_W-1:0] reported,
                                                      input logic fatal);
        logic [LEN_W-1:0] moved;
        logic [LEN_W-1:0] skipped;
        logic [LEN_W:0]   run_sum;
        logic             done_now;
        transfer_reply_t  reply;
        done_now = 1'b0;
        if (kind == KIND_START) begin
            next_addr = start_addr;
            bytes_left = start_len;
            bytes_moved = '0;
            paging = 1'b0;
            clean_run = '0;
            issued_size = '0;
            if (start_addr == '0 || start_len == '0) begin
                done_now = 1'b1;
            end else begin
                busy = 1'b1;
            end
        end else if (!busy || fatal) begin
            done_now = 1'b1;
        end else begin
            moved = (reported > issued_size) ? issued_size : reported;
            if (moved != '0) begin
                bytes_moved = bytes_moved + moved;
                next_addr = next_addr + 64'(moved);
                bytes_left = bytes_left - moved;
                if (paging) begin
                    run_sum = {1'b0, clean_run} + {1'b0, moved};
                    clean_run = run_sum[LEN_W] ? '1 : run_sum[LEN_W-1:0];
                    if (clean_run >= retry_bytes) begin
                        paging = 1'b0;
                        clean_run = '0;
                    end
                end
                if (moved != issued_size && !skip_faults) begin
                    done_now = 1'b1;
                end
            end else if (!skip_faults) begin
                done_now = 1'b1;
            end else if (!paging) begin
                paging = 1'b1;
                clean_run = '0;
            end else begin
                skipped = page_limited(next_addr);
                next_addr = next_addr + 64'(skipped);
                bytes_left = bytes_left - skipped;
                clean_run = '0;
            end
            if (!done_now && bytes_left == '0) begin
                done_now = 1'b1;
            end
        end
        if (done_now) begin
            busy = 1'b0;
            reply = '{'0, '0, 1'b1, bytes_moved};
        end else begin
            issued_size = paging ? page_limited(next_addr) : bytes_left;
            reply = '{next_addr, issued_size, 1'b0, bytes_moved};
        end
        return reply;
    endfunction

    always @(posedge aclk) begin : watch
        transfer_reply_t got;
        transfer_reply_t want;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_SKIP_MODE) begin
                    skip_faults = cfg_data[0];
                end else if (cfg_index == CFG_RETRY_THRESHOLD) begin
                    retry_bytes = cfg_data[LEN_W-1:0];
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = '{m_axis_tdata[63:0], m_axis_tdata[95:64], m_axis_tuser,
                        m_axis_tdata[127:96]};
                if (awaited_replies.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: unexpected result addr %h size %h fin %b total %h",
                                 $realtime, got.address, got.size, got.finished, got.total);
                    end
                end else begin
                    want = awaited_replies.pop_front();
                    if (got.address !== want.address || got.size !== want.size ||
                        got.finished !== want.finished || got.total !== want.total) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%0t: expected addr %h size %h fin %b total %h",
                                     $realtime, want.address, want.size, want.finished,
                                     want.total);
                            $display("%0t:   actual addr %h size %h fin %b total %h",
                                     $realtime, got.address, got.size, got.finished,
                                     got.total);
                        end
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                awaited_replies.push_back(sequence_step(s_axis_tuser, s_axis_tdata[63:0],
                                                        s_axis_tdata[95:64],
                                                        s_axis_tdata[127:96],
                                                        s_axis_tdata[128]));
            end
        end
        outstanding = awaited_replies.size();
    end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import fsts_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int RX_HOLD = 80;
    localparam int ITEMS_PER_PHASE = 300;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES = 10;
    localparam int PHASES = 6;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic                  m_axis_tuser;

    int fail_count;
    int pending;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int rx_hold_cycles = 0;
    int quiet_cycles = 0;

    bit               phase_skip[PHASES] = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0};
    logic [LEN_W-1:0] phase_threshold[PHASES] = '{32'd65536, 32'd1, 32'd8192,
                                                  32'hFFFF_FFFF, 32'd0, 32'd1};

    always #5 aclk = ~aclk;

    fault_skipping_transfer_sequencer dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    transfer_sequence_checker u_checker (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .mismatches(fail_count),
        .outstanding(pending)
    );

    initial begin
        forever begin
            @(negedge aclk);
            if (rx_hold_cycles > 0) begin
                m_axis_tready <= 1'b0;
                rx_hold_cycles--;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("fault_skipping_transfer_sequencer regression: fail");
            $finish;
        end
    end

    task automatic send_item(input logic kind, input logic [ADDR_W-1:0] addr,
                             input logic [LEN_W-1:0] len, input logic [LEN_W-1:0] done,
                             input logic fatal);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= kind;
        s_axis_tdata <= {7'b0, fatal, done, len, addr};
        do @(posedge aclk); while (!s_axis_tready);
        @(negedge aclk);
    endtask

    task automatic send_start(input logic [ADDR_W-1:0] addr, input logic [LEN_W-1:0] len);
        send_item(KIND_START, addr, len, $urandom, 1'($urandom));
    endtask

    task automatic send_completion(input logic [LEN_W-1:0] done, input logic fatal);
        send_item(KIND_COMPLETE, {$urandom, $urandom}, $urandom, done, fatal);
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic program_registers(input bit skip, input logic [LEN_W-1:0] threshold);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_SKIP_MODE;
        cfg_data <= {31'b0, skip};
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_index <= CFG_RETRY_THRESHOLD;
        cfg_data <= threshold;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [ADDR_W-1:0] pick_address();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 25) begin
            return {$urandom, $urandom};
        end else if (roll < 45) begin
            return {32'hFFFF_FFFF, 32'hFFFF_FFFF - 32'($urandom_range(0, 3 * PAGE_SIZE))};
        end else if (roll < 75) begin
            return ({$urandom, $urandom} & ~64'(PAGE_SIZE - 1)) |
                   64'(PAGE_SIZE - $urandom_range(1, 64));
        end
        return {32'($urandom_range(0, 15)), $urandom} | 64'd1;
    endfunction

    function automatic logic [LEN_W-1:0] pick_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
            return $urandom;
        end else if (roll < 20) begin
            return 32'd1;
        end
        return 32'($urandom_range(1, 3 * PAGE_SIZE));
    endfunction

    task automatic send_random_completion();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 5) begin
            send_completion($urandom, 1'b1);
        end else if (roll < 30) begin
            send_completion(32'd0, 1'b0);
        end else if (roll < 65) begin
            send_completion($urandom | 32'h8000_0000, 1'b0);
        end else if (roll < 85) begin
            send_completion(32'($urandom_range(1, PAGE_SIZE)), 1'b0);
        end else begin
            send_completion($urandom, 1'b0);
        end
    endtask

    task automatic run_random(input int count);
        int sent;
        int roll;
        int steps;
        sent = 0;
        while (sent < count) begin
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
                send_item(KIND_COMPLETE, {$urandom, $urandom}, $urandom, $urandom,
                          1'($urandom));
                sent++;
            end else if (roll < 12) begin
                if ($urandom_range(0, 1) == 0) begin
                    send_start('0, $urandom);
                end else begin
                    send_start({$urandom, $urandom}, '0);
                end
                sent++;
            end else begin
                send_start(pick_address(), pick_length());
                sent++;
                steps = $urandom_range(1, 12);
                for (int i = 0; i < steps && sent < count; i++) begin
                    send_random_completion();
                    sent++;
                end
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        tx_idle_pct = 24;
        rx_idle_pct = 51;

        send_completion(32'd100, 1'b0);
        send_start('0, 32'd100);
        send_start(64'h1000, '0);
        settle();
        program_registers(1'b0, RETRY_RESET);
        send_start(64'hFFFF_FFFF_FFFF_F000, 32'hFFFF_FFFF);
        send_completion(32'h2000, 1'b0);
        send_completion(32'hFFFF_FFFF, 1'b0);
        send_start(64'h10, 32'd1000);
        send_completion(32'd500, 1'b0);
        send_start(64'h20, 32'd5000);
        send_completion(32'd0, 1'b0);
        send_start(64'h30, 32'd5000);
        send_completion(32'd100, 1'b1);
        send_start(64'h40, 32'd300);
        send_start(64'h5000, 32'd200);
        send_completion(32'd200, 1'b0);
        settle();

        program_registers(1'b1, 32'd4096);
        send_start(64'h1F00, 32'd20000);
        send_completion(32'd0, 1'b0);
        send_completion(32'd0, 1'b0);
        send_completion(32'hFFFF_FFFF, 1'b0);
        send_completion(32'd0, 1'b0);
        send_completion(32'd100, 1'b0);
        send_completion(32'd0, 1'b1);
        send_start(64'hFFFF_FFFF_FFFF_FFFF, 32'd10);
        send_completion(32'd0, 1'b0);
        send_completion(32'd0, 1'b0);
        send_completion(32'hFFFF_FFFF, 1'b0);

        for (int phase = 0; phase < PHASES; phase++) begin
            settle();
            program_registers(phase_skip[phase], phase_threshold[phase]);
            if (phase < 2) begin
                tx_idle_pct = 24;
                rx_idle_pct = 51;
            end else if (phase < 4) begin
                tx_idle_pct = 51;
                rx_idle_pct = 24;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if (phase == 1 || phase == 4) begin
                rx_hold_cycles = RX_HOLD;
            end
            run_random(ITEMS_PER_PHASE);
        end

        settle();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("fault_skipping_transfer_sequencer regression: pass");
        end else begin
            $display("fault_skipping_transfer_sequencer regression: fail");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/fsts_pkg.sv
rtl/core/fsts_front.sv
rtl/core/fsts_queue.sv
rtl/core/fsts_back.sv
rtl/core/fault_skipping_transfer_sequencer.sv
sim/transfer_sequence_checker.sv
sim/testbench.sv
